// File: src/hkrt_pkg.sv
// Package for the boot-keyboard report table.
// Holds command codes, field widths, the compare-unit result type and a bit-count helper.
// No dependencies.
package hkrt_pkg;

  localparam int KEY_W       = 8;
  localparam int CMD_W       = 2;
  localparam int CNT_W       = 4;
  localparam int SHOWN_SLOTS = 6;

  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  localparam logic [4:0]       MOD_PREFIX = 5'b11100;
  localparam logic [CNT_W-1:0] CNT_MAX    = 4'd15;

  typedef struct packed {
    logic             is_zero;
    logic             is_match;
    logic [CNT_W-1:0] cnt_inc;
  } cmp_res_t;

  function automatic logic [CNT_W-1:0] bit_count8(input logic [KEY_W-1:0] v);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < KEY_W; i++) begin
      n = n + CNT_W'(v[i]);
    end
    return n;
  endfunction

endpackage

// File: src/hkrt_in_if.sv
// Input channel of the report table: command and keycode with valid/ready.
// Depends on hkrt_pkg.
interface hkrt_in_if import hkrt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [KEY_W-1:0] keycode;

  modport source (output valid, output cmd, output keycode, input ready);
  modport sink   (input valid, input cmd, input keycode, output ready);
endinterface

// File: src/hkrt_out_if.sv
// Result channel of the report table: status, count and the report after each command.
// Depends on hkrt_pkg.
interface hkrt_out_if import hkrt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             status;
  logic [CNT_W-1:0] count;
  logic             changed;
  logic [KEY_W-1:0] modifier_bits;
  logic [KEY_W-1:0] key_slot_0;
  logic [KEY_W-1:0] key_slot_1;
  logic [KEY_W-1:0] key_slot_2;
  logic [KEY_W-1:0] key_slot_3;
  logic [KEY_W-1:0] key_slot_4;
  logic [KEY_W-1:0] key_slot_5;

  modport source (output valid, output status, output count, output changed,
                  output modifier_bits, output key_slot_0, output key_slot_1,
                  output key_slot_2, output key_slot_3, output key_slot_4,
                  output key_slot_5, input ready);
  modport sink   (input valid, input status, input count, input changed,
                  input modifier_bits, input key_slot_0, input key_slot_1,
                  input key_slot_2, input key_slot_3, input key_slot_4,
                  input key_slot_5, output ready);
endinterface

// File: src/hkrt_slot_cmp.sv
// Shared slot compare unit: tests one slot value for empty and for a key match,
// and forms the saturating count increment. Depends on hkrt_pkg.
module hkrt_slot_cmp import hkrt_pkg::*; (
  input  logic [KEY_W-1:0] operand,
  input  logic [KEY_W-1:0] key,
  input  logic [CNT_W-1:0] cnt,
  output cmp_res_t         res
);

  always_comb begin
    res.is_zero  = (operand == '0);
    res.is_match = (operand == key);
    res.cnt_inc  = (cnt == CNT_MAX) ? cnt : cnt + 1'b1;
  end

endmodule

// File: src/hid_keyboard_report_table_core.sv
// Top level of the boot-keyboard report table: slot registers, sequencer, output register.
// Depends on hkrt_pkg, hkrt_in_if, hkrt_out_if and hkrt_slot_cmp.
//
// The block keeps one boot-keyboard report (modifier bitmap and SLOT_COUNT packed key slots)
// and answers every command transfer with one result transfer showing the report afterward.
// One comparator visits one slot per cycle. Modifier codes, keycode zero and the unused
// command are answered without visiting the slots; add, remove and clear visit the slots
// in turn, and remove then shifts the later keys, starting at the slot where the search
// stopped. The input is ready again in the cycle after the result is loaded.
// The block takes no new command until the current one has reached the output register;
// that register lets a new command start while the previous result waits.
module hid_keyboard_report_table_core import hkrt_pkg::*; #(
  parameter int SLOT_COUNT = 6
) (
  input  logic     clk,
  input  logic     rst_n,
  hkrt_in_if.sink  in_ch,
  hkrt_out_if.source out_ch
);

  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = $clog2(SLOT_COUNT + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_SHIFT = 5'b00100,
    S_CLEAR = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CMD_W-1:0] cmd_r, cmd_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             full_r, full_nxt;
  logic [KEY_W-1:0] mod_r, mod_nxt;
  logic [KEY_W-1:0] slots_r [SLOT_COUNT];
  logic [KEY_W-1:0] slots_nxt [SLOT_COUNT];

  logic             out_valid_r, out_valid_nxt;
  logic             out_status_r;
  logic [CNT_W-1:0] out_count_r;
  logic             out_changed_r;
  logic [KEY_W-1:0] out_mod_r;
  logic [KEY_W-1:0] out_slot_r [SHOWN_SLOTS];

  logic [IW-1:0]    cur_idx, nxt_idx;
  logic             is_last;
  logic [KEY_W-1:0] cur_slot, nxt_slot, operand;
  logic             in_xfer, out_load;
  logic             mod_hit;
  logic [KEY_W-1:0] mod_bit;
  cmp_res_t         cmp;

  assign cur_idx  = idx_r[IW-1:0];
  assign nxt_idx  = cur_idx + 1'b1;
  assign is_last  = (idx_r == CW'(SLOT_COUNT - 1));
  assign cur_slot = slots_r[cur_idx];
  assign nxt_slot = is_last ? '0 : slots_r[nxt_idx];
  assign operand  = (state_r == S_SHIFT) ? nxt_slot : cur_slot;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  assign mod_hit = (in_ch.keycode[7:3] == MOD_PREFIX);
  assign mod_bit = KEY_W'(1) << in_ch.keycode[2:0];

  hkrt_slot_cmp u_cmp (
    .operand (operand),
    .key     (key_r),
    .cnt     (cnt_r),
    .res     (cmp)
  );

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    key_nxt   = key_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    full_nxt  = full_r;
    mod_nxt   = mod_r;
    for (int j = 0; j < SLOT_COUNT; j++) begin
      slots_nxt[j] = slots_r[j];
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          cmd_nxt   = in_ch.cmd;
          key_nxt   = in_ch.keycode;
          idx_nxt   = '0;
          cnt_nxt   = '0;
          full_nxt  = 1'b0;
          state_nxt = S_DONE;
          priority if (in_ch.cmd == CMD_CLEAR) begin
            cnt_nxt   = bit_count8(mod_r);
            mod_nxt   = '0;
            state_nxt = S_CLEAR;
          end else if (in_ch.cmd == CMD_ADD && mod_hit) begin
            cnt_nxt = CNT_W'((mod_r & mod_bit) == '0);
            mod_nxt = mod_r | mod_bit;
          end else if (in_ch.cmd == CMD_REMOVE && mod_hit) begin
            cnt_nxt = CNT_W'((mod_r & mod_bit) != '0);
            mod_nxt = mod_r & ~mod_bit;
          end else if ((in_ch.cmd == CMD_ADD || in_ch.cmd == CMD_REMOVE) &&
                       in_ch.keycode != '0) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (cmd_r == CMD_ADD) begin
          priority if (cmp.is_zero) begin
            slots_nxt[cur_idx] = key_r;
            cnt_nxt            = cmp.cnt_inc;
            state_nxt          = S_DONE;
          end else if (cmp.is_match) begin
            state_nxt = S_DONE;
          end else if (is_last) begin
            full_nxt  = 1'b1;
            state_nxt = S_DONE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end else begin
          priority if (cmp.is_zero) begin
            state_nxt = S_DONE;
          end else if (cmp.is_match) begin
            state_nxt = S_SHIFT;
          end else if (is_last) begin
            state_nxt = S_DONE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      S_SHIFT: begin
        if (cmp.is_zero) begin
          slots_nxt[cur_idx] = '0;
          cnt_nxt            = cmp.cnt_inc;
          state_nxt          = S_DONE;
        end else begin
          slots_nxt[cur_idx] = nxt_slot;
          idx_nxt            = idx_r + 1'b1;
        end
      end
      S_CLEAR: begin
        if (!cmp.is_zero) begin
          cnt_nxt = cmp.cnt_inc;
        end
        slots_nxt[cur_idx] = '0;
        if (is_last) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      mod_r       <= '0;
      out_valid_r <= 1'b0;
      for (int j = 0; j < SLOT_COUNT; j++) begin
        slots_r[j] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      mod_r       <= mod_nxt;
      out_valid_r <= out_valid_nxt;
      for (int j = 0; j < SLOT_COUNT; j++) begin
        slots_r[j] <= slots_nxt[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    key_r  <= key_nxt;
    cnt_r  <= cnt_nxt;
    full_r <= full_nxt;
    if (out_load) begin
      out_status_r  <= full_r;
      out_count_r   <= cnt_r;
      out_changed_r <= (cnt_r != '0);
      out_mod_r     <= mod_r;
    end
  end

  for (genvar g = 0; g < SHOWN_SLOTS; g++) begin : g_shown
    if (g < SLOT_COUNT) begin : g_real
      always_ff @(posedge clk) begin
        if (out_load) begin
          out_slot_r[g] <= slots_r[g];
        end
      end
    end else begin : g_empty
      always_ff @(posedge clk) begin
        if (out_load) begin
          out_slot_r[g] <= '0;
        end
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.count         = out_count_r;
  assign out_ch.changed       = out_changed_r;
  assign out_ch.modifier_bits = out_mod_r;
  assign out_ch.key_slot_0    = out_slot_r[0];
  assign out_ch.key_slot_1    = out_slot_r[1];
  assign out_ch.key_slot_2    = out_slot_r[2];
  assign out_ch.key_slot_3    = out_slot_r[3];
  assign out_ch.key_slot_4    = out_slot_r[4];
  assign out_ch.key_slot_5    = out_slot_r[5];

  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r != S_IDLE)
    else $error("sequencer still idle after an input transfer");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r < CW'(SLOT_COUNT))
    else $error("slot index beyond the last slot");

  a_full_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r) |-> (out_count_r == '0 && !out_changed_r))
    else $error("full status reported together with a change");

  for (genvar g = 0; g + 1 < SLOT_COUNT; g++) begin : g_packed_chk
    a_packed: assert property (@(posedge clk) disable iff (!rst_n)
      (state_r == S_IDLE && slots_r[g] == '0) |-> slots_r[g+1] == '0)
      else $error("key slots not packed toward slot zero");
  end

endmodule
